// ===== hdl/mrtu_pkg.sv =====
`timescale 1ns / 1ps

package mrtu_pkg;

    // Frame limits
    localparam int unsigned FRAME_CAPACITY = 256;
    localparam int unsigned COUNT_W        = 9;
    localparam logic [COUNT_W-1:0] MIN_FRAME = 9'd6;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 9'd255;

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Supported function codes (the 1..6 range and two outside it), broadcast address
    localparam logic [7:0] FC_MULTI_COILS = 8'h0F;
    localparam logic [7:0] FC_MULTI_REGS  = 8'h10;
    localparam logic [7:0] FC_LOW         = 8'h01;
    localparam logic [7:0] FC_HIGH        = 8'h06;
    localparam logic [7:0] BCAST_ADDR     = 8'h00;

    // Configuration register indexes
    localparam logic [1:0] CFG_RX_ENABLE = 2'd0;
    localparam logic [1:0] CFG_OWN_ADDR  = 2'd1;
    localparam logic [1:0] CFG_GAP_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } rx_beat_t;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] function_code;
        logic [7:0] frame_length;
        logic       is_broadcast;
        logic       function_supported;
    } frame_info_t;

    // One byte through the reflected CRC, bit at a time, unrolled
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    function automatic logic code_supported(input logic [7:0] fc);
        return ((fc >= FC_LOW) && (fc <= FC_HIGH)) ||
               (fc == FC_MULTI_COILS) || (fc == FC_MULTI_REGS);
    endfunction

endpackage

// ===== hdl/mrtu_in_stage.sv =====
`timescale 1ns / 1ps

module mrtu_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrtu_pkg::rx_beat_t s_data,
    output logic              in_valid,
    output mrtu_pkg::rx_beat_t in_data,
    input  logic              in_take
);

    logic               valid_reg;
    mrtu_pkg::rx_beat_t data_reg;

    // Free when empty or when the held beat is consumed this cycle
    assign s_ready  = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ===== hdl/mrtu_frame_core.sv =====
`timescale 1ns / 1ps

module mrtu_frame_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_wdata,
    input  logic                    in_valid,
    input  mrtu_pkg::rx_beat_t      in_data,
    output logic                    in_take,
    output logic                    m_valid,
    input  logic                    m_ready,
    output mrtu_pkg::frame_info_t   m_data
);

    // Configuration
    logic        rx_enable_reg;
    logic [7:0]  own_addr_reg;
    logic [15:0] gap_limit_reg;

    // Frame state
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] last_time_reg;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  second_byte_reg, second_byte_next;

    // Result register
    logic                  m_valid_reg, m_valid_next;
    mrtu_pkg::frame_info_t m_data_reg, m_data_next;

    // Datapath
    logic [31:0] elapsed;
    logic        gap_restart;
    logic [7:0]  count_eff;
    logic [15:0] crc_eff;
    logic [15:0] crc_new;
    logic [mrtu_pkg::COUNT_W-1:0] count;
    logic        frame_end;
    logic        frame_full;
    logic        addr_match;
    logic        step;

    assign in_take = in_valid && (!m_valid_reg || m_ready);
    assign step    = in_take && rx_enable_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_enable_reg <= 1'b0;
            own_addr_reg  <= 8'd1;
            gap_limit_reg <= 16'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mrtu_pkg::CFG_RX_ENABLE: rx_enable_reg <= cfg_wdata[0];
                mrtu_pkg::CFG_OWN_ADDR:  own_addr_reg  <= cfg_wdata[7:0];
                mrtu_pkg::CFG_GAP_LIMIT: gap_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Byte processing: gap check, CRC, count, end-of-frame decision
    always_comb begin
        elapsed     = in_data.time_ms - last_time_reg;
        gap_restart = (byte_count_reg != 8'd0) && (elapsed > {16'd0, gap_limit_reg});
        count_eff   = gap_restart ? 8'd0 : byte_count_reg;
        crc_eff     = gap_restart ? mrtu_pkg::CRC_INIT : crc_reg;

        first_byte_next  = (count_eff == 8'd0) ? in_data.rx_byte : first_byte_reg;
        second_byte_next = (count_eff == 8'd1) ? in_data.rx_byte : second_byte_reg;
        crc_new = mrtu_pkg::crc_add_byte(crc_eff, in_data.rx_byte);
        count   = {1'b0, count_eff} + 9'd1;

        frame_end  = (count >= mrtu_pkg::MIN_FRAME) && (count <= mrtu_pkg::MAX_COUNT) &&
                     (crc_new == 16'd0);
        frame_full = (count >= mrtu_pkg::COUNT_W'(mrtu_pkg::FRAME_CAPACITY)) ||
                     (count > mrtu_pkg::MAX_COUNT);
        addr_match = (first_byte_next == own_addr_reg) ||
                     (first_byte_next == mrtu_pkg::BCAST_ADDR);

        if (frame_end || frame_full) begin
            byte_count_next = 8'd0;
            crc_next        = mrtu_pkg::CRC_INIT;
        end else begin
            byte_count_next = count[7:0];
            crc_next        = crc_new;
        end

        m_data_next.station_address    = first_byte_next;
        m_data_next.function_code      = second_byte_next;
        m_data_next.frame_length       = count[7:0];
        m_data_next.is_broadcast       = (first_byte_next == mrtu_pkg::BCAST_ADDR);
        m_data_next.function_supported = mrtu_pkg::code_supported(second_byte_next);

        // Result register: load on a reported frame, drain on output beat
        if (step && frame_end && addr_match) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= 8'd0;
            crc_reg         <= mrtu_pkg::CRC_INIT;
            last_time_reg   <= 32'd0;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                byte_count_reg  <= byte_count_next;
                crc_reg         <= crc_next;
                last_time_reg   <= in_data.time_ms;
                first_byte_reg  <= first_byte_next;
                second_byte_reg <= second_byte_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && frame_end && addr_match) begin
            m_data_reg <= m_data_next;
        end
    end

`ifndef ASSERT_OFF
    // Reported frames are never shorter than the minimum
    a_min_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.frame_length >= 8'd6))
        else $error("reported frame shorter than minimum");

    // Broadcast flag agrees with the address
    a_bcast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.is_broadcast == (m_data_reg.station_address == 8'd0)))
        else $error("broadcast flag inconsistent with address");

    // A finished frame leaves the receiver ready for a fresh one
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && frame_end) |=> (byte_count_reg == 8'd0 && crc_reg == mrtu_pkg::CRC_INIT))
        else $error("frame state not cleared after frame end");

    // Bytes taken while disabled leave the frame state untouched
    a_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && !rx_enable_reg) |=> ($stable(byte_count_reg) && $stable(crc_reg)))
        else $error("frame state changed while receiver disabled");

    // A stalled result is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("stalled result was lost or changed");
`endif

endmodule

// ===== hdl/modbus_rtu_frame_receiver.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// s_        s_valid / s_ready      s_data  (rx_byte, time_ms)
// m_        m_valid / m_ready      m_data  (station_address, function_code,
//                                           frame_length, is_broadcast,
//                                           function_supported)
// cfg_      cfg_wr_en              cfg_index, cfg_wdata
//
// One byte per cycle sustained while no result is stalled; a result is valid
// once its byte has passed the input register, then gap check + unrolled byte CRC
// into the result register. The frame state is updated once per byte.
// Reset (aresetn low, synchronous) clears the frame and loads the register
// defaults. A stalled result holds; one more byte is buffered meanwhile.

module modbus_rtu_frame_receiver (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mrtu_pkg::rx_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mrtu_pkg::frame_info_t m_data
);

    logic               in_valid;
    logic               in_take;
    mrtu_pkg::rx_beat_t in_data;

    mrtu_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_take  (in_take)
    );

    mrtu_frame_core u_frame_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_take   (in_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== dv/modbus_rtu_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_test;

    import mrtu_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_ERR_PRINTS = 40;
    localparam int RANDOM_BYTES   = 1300;
    localparam int PHASE_COUNT    = 4;
    localparam int RECONFIG_EVERY = 160;

    // Index 3 decodes to no register
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CRC,
        FLAW_TRUNCATED,
        FLAW_SILENCE
    } frame_flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    rx_beat_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    frame_info_t m_data;

    modbus_rtu_frame_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial forever #10 aclk = ~aclk;

    // Run bookkeeping
    int          error_count    = 0;
    int          cycle_count    = 0;
    int          beats_accepted = 0;
    int          bytes_taken    = 0;
    int          frames_checked = 0;
    int          cfg_writes     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic [31:0] now_ms         = '0;
    logic [7:0]  frame_buf[$];

    // Shadow of the receiver: registers and open-frame state
    logic        rx_enable;
    logic [7:0]  rx_own_addr;
    logic [15:0] rx_gap_ms;
    int unsigned rx_count;
    logic [15:0] rx_crc;
    logic [31:0] rx_last_ms;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
    frame_info_t pending_frames[$];

    logic [7:0] known_codes[8] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                                   FC_MULTI_COILS, FC_MULTI_REGS};

    // Reflected CRC-16, one data bit folded into the feedback per step
    function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                      input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic frame_code_known(input logic [7:0] fc);
        return fc inside {[FC_LOW:FC_HIGH], FC_MULTI_COILS, FC_MULTI_REGS};
    endfunction

    // Advance the shadow frame by one taken byte, queue the frame info if one ends
    task automatic track_rx_byte(input rx_beat_t beat);
        logic [31:0] silence;
        int unsigned count;
        frame_info_t info;
        silence = beat.time_ms - rx_last_ms;
        if (rx_count > 0 && silence > {16'h0000, rx_gap_ms}) begin
            rx_count = 0;
            rx_crc   = CRC_INIT;
        end
        rx_last_ms = beat.time_ms;
        if (rx_count == 0) begin
            rx_first = beat.rx_byte;
        end else if (rx_count == 1) begin
            rx_second = beat.rx_byte;
        end
        rx_crc = crc16_modbus_next(rx_crc, beat.rx_byte);
        count  = rx_count + 1;
        if (count >= MIN_FRAME && count <= MAX_COUNT && rx_crc == 16'h0000) begin
            rx_count = 0;
            rx_crc   = CRC_INIT;
            if (rx_first == rx_own_addr || rx_first == BCAST_ADDR) begin
                info.station_address    = rx_first;
                info.function_code      = rx_second;
                info.frame_length       = count[7:0];
                info.is_broadcast       = (rx_first == BCAST_ADDR);
                info.function_supported = frame_code_known(rx_second);
                pending_frames.push_back(info);
            end
        end else if (count >= FRAME_CAPACITY) begin
            rx_count = 0;
            rx_crc   = CRC_INIT;
        end else begin
            rx_count = count;
        end
    endtask

    // Shadow update from what the block sees at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_enable   = 1'b0;
            rx_own_addr = 8'd1;
            rx_gap_ms   = 16'd4;
            rx_count    = 0;
            rx_crc      = CRC_INIT;
            rx_last_ms  = '0;
            rx_first    = '0;
            rx_second   = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RX_ENABLE: rx_enable   = cfg_wdata[0];
                    CFG_OWN_ADDR:  rx_own_addr = cfg_wdata[7:0];
                    CFG_GAP_LIMIT: rx_gap_ms   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                beats_accepted++;
                if (rx_enable) begin
                    bytes_taken++;
                    track_rx_byte(s_data);
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_ERR_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("frame %0d %s got 0x%02h want 0x%02h",
                                      frames_checked, name, got, want));
        end
    endtask

    // Result beats against the oldest expected frame info
    always @(posedge aclk) begin
        frame_info_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected frame info addr 0x%02h fc 0x%02h",
                                          m_data.station_address, m_data.function_code));
            end else begin
                want = pending_frames.pop_front();
                check_field("station_address", m_data.station_address,
                            want.station_address);
                check_field("function_code", m_data.function_code, want.function_code);
                check_field("frame_length", m_data.frame_length, want.frame_length);
                check_field("is_broadcast", {7'd0, m_data.is_broadcast},
                            {7'd0, want.is_broadcast});
                check_field("function_supported", {7'd0, m_data.function_supported},
                            {7'd0, want.function_supported});
            end
            frames_checked++;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d frames still expected",
                 cycle_count, pending_frames.size());
        $display("DONE: errors detected");
        $finish;
    end

    // One byte beat; returns once it is accepted, after an optional random idle pause
    task automatic send_byte(input logic [7:0] b, input int unsigned delta);
        rx_beat_t beat;
        now_ms       = now_ms + delta;
        beat.rx_byte = b;
        beat.time_ms = now_ms;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Stop sending and let every outstanding frame info and in-flight byte drain
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
        // let the shadow registers settle before returning
        @(posedge aclk);
    endtask

    // Unused upper data bits carry random junk
    task automatic set_enable(input logic en);
        logic [15:0] w;
        w    = $urandom;
        w[0] = en;
        cfg_write(CFG_RX_ENABLE, w);
    endtask

    task automatic set_own_address(input logic [7:0] addr);
        logic [15:0] w;
        w      = $urandom;
        w[7:0] = addr;
        cfg_write(CFG_OWN_ADDR, w);
    endtask

    task automatic set_gap_limit(input logic [15:0] gap);
        cfg_write(CFG_GAP_LIMIT, gap);
    endtask

    // Inter-byte delay inside a frame, the exact limit now and then
    function automatic int unsigned in_frame_delta();
        if ($urandom_range(0, 15) == 0) begin
            return rx_gap_ms;
        end
        return $urandom_range(0, rx_gap_ms);
    endfunction

    function automatic int unsigned silence_delta();
        if ($urandom_range(0, 3) == 0) begin
            return rx_gap_ms + 1;
        end
        return rx_gap_ms + 1 + $urandom_range(0, 50);
    endfunction

    // Address, function, payload, then CRC low byte first
    task automatic fill_frame(input logic [7:0] addr, input logic [7:0] fc,
                              input int payload_len);
        logic [15:0] crc;
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
        for (int i = 0; i < payload_len; i++) begin
            frame_buf.push_back($urandom_range(0, 255));
        end
        crc = CRC_INIT;
        foreach (frame_buf[i]) begin
            crc = crc16_modbus_next(crc, frame_buf[i]);
        end
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endtask

    // Frame preceded by enough silence to start fresh, with an optional flaw
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] fc,
                              input int payload_len, input frame_flaw_t flaw);
        int          cut;
        int          quiet_at;
        int unsigned d;
        fill_frame(addr, fc, payload_len);
        if (flaw == FLAW_BAD_CRC) begin
            cut = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[cut] = frame_buf[cut] ^ (8'h01 << $urandom_range(0, 7));
        end
        cut = frame_buf.size();
        if (flaw == FLAW_TRUNCATED) begin
            cut = $urandom_range(1, frame_buf.size() - 1);
        end
        quiet_at = -1;
        if (flaw == FLAW_SILENCE) begin
            quiet_at = $urandom_range(1, frame_buf.size() - 1);
        end
        for (int i = 0; i < cut; i++) begin
            if (i == 0) begin
                d = silence_delta();
            end else if (i == quiet_at) begin
                d = silence_delta();
            end else begin
                d = in_frame_delta();
            end
            send_byte(frame_buf[i], d);
        end
    endtask

    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return rx_own_addr;
        end else if (r < 60) begin
            return BCAST_ADDR;
        end
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [7:0] pick_function();
        if ($urandom_range(0, 99) < 60) begin
            return known_codes[$urandom_range(0, 7)];
        end
        return $urandom_range(0, 255);
    endfunction

    // Out of reset the receiver is off: a good frame goes nowhere
    task automatic test_disabled_after_reset();
        send_frame(8'h01, 8'h03, 2, FLAW_NONE);
        send_byte(8'hFF, 0);
    endtask

    // Unused index is dropped, then the reset address and gap are used
    task automatic test_register_defaults();
        cfg_write(CFG_UNUSED, 16'hFFFF);
        set_enable(1'b1);
        send_frame(8'h01, 8'h03, 2, FLAW_NONE);
        send_frame(8'h01, 8'h06, 4, FLAW_NONE);
    endtask

    // Own, broadcast and foreign stations; function code extremes
    task automatic test_address_filter();
        send_frame(BCAST_ADDR, FC_MULTI_REGS, 2, FLAW_NONE);
        send_frame(8'h7E, FC_MULTI_COILS, 2, FLAW_NONE);
        send_frame(8'h01, 8'h00, 2, FLAW_NONE);
        send_frame(8'h01, 8'hFF, 3, FLAW_NONE);
        set_own_address(8'hFF);
        send_frame(8'hFF, 8'h05, 2, FLAW_NONE);
        send_frame(8'h01, 8'h05, 2, FLAW_NONE);
        set_own_address(8'h00);
        send_frame(8'h00, 8'h01, 2, FLAW_NONE);
        set_own_address(8'h01);
    endtask

    // Silence at and past the limit, timestamp wrap, gap extremes
    task automatic test_silence_limit();
        set_gap_limit(16'd4);
        now_ms = 32'hFFFF_FFF0 - 32'd100;
        fill_frame(8'h01, 8'h04, 2);
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], (i == 0) ? 100 : 4);
        end
        send_frame(8'h01, 8'h05, 2, FLAW_SILENCE);
        send_frame(8'h01, 8'h02, 2, FLAW_NONE);
        set_gap_limit(16'd0);
        send_frame(8'h01, 8'h01, 2, FLAW_NONE);
        send_frame(8'h01, 8'h01, 3, FLAW_SILENCE);
        set_gap_limit(16'hFFFF);
        fill_frame(BCAST_ADDR, 8'h03, 2);
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], (i == 0) ? 70000 : 65535);
        end
        send_frame(8'h01, 8'h03, 2, FLAW_SILENCE);
        set_gap_limit(16'd4);
    endtask

    // Longest frame that can end, one that is one byte too long, then recovery
    task automatic test_frame_full();
        send_frame(8'h01, 8'h03, 251, FLAW_NONE);
        send_frame(8'h01, 8'h10, 252, FLAW_NONE);
        send_frame(8'h01, 8'h04, 2, FLAW_NONE);
    endtask

    // Bytes while disabled leave the open frame untouched
    task automatic test_disable_midframe();
        fill_frame(8'h01, 8'h02, 4);
        for (int i = 0; i < 3; i++) begin
            send_byte(frame_buf[i], (i == 0) ? silence_delta() : 0);
        end
        set_enable(1'b0);
        repeat (4) send_byte($urandom_range(0, 255), 0);
        set_enable(1'b1);
        for (int i = 3; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], 0);
        end
    endtask

    // Mostly well-formed frames with random content, plus broken ones and noise
    task automatic test_random_traffic();
        int unsigned idle_set[PHASE_COUNT][2] = '{'{0, 0}, '{60, 0}, '{0, 60},
                                                   '{38, 38}};
        int          phase_end;
        int          next_reconfig;
        int          r;
        int          n;
        int          plen;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            send_idle_pct  = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            phase_end      = bytes_taken + RANDOM_BYTES / PHASE_COUNT;
            next_reconfig  = bytes_taken;
            while (bytes_taken < phase_end) begin
                // new address and gap now and then, extremes included
                if (bytes_taken >= next_reconfig) begin
                    r = $urandom_range(0, 9);
                    set_own_address((r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
                                    $urandom_range(0, 255));
                    r = $urandom_range(0, 9);
                    set_gap_limit((r < 2) ? 16'h0000 : (r < 4) ? 16'hFFFF :
                                  (r < 8) ? $urandom_range(1, 20) :
                                  $urandom_range(0, 65535));
                    if ($urandom_range(0, 1) == 0) begin
                        now_ms = $urandom;
                    end
                    next_reconfig = bytes_taken + RECONFIG_EVERY;
                end
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
                       $urandom_range(2, 8);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_frame(pick_address(), pick_function(), plen, FLAW_NONE);
                end else if (r < 78) begin
                    send_frame(pick_address(), pick_function(), plen, FLAW_BAD_CRC);
                end else if (r < 84) begin
                    send_frame(pick_address(), pick_function(), $urandom_range(0, 8),
                               FLAW_TRUNCATED);
                end else if (r < 90) begin
                    send_frame(pick_address(), pick_function(), plen, FLAW_SILENCE);
                end else if (r < 97) begin
                    n = $urandom_range(1, 10);
                    repeat (n) begin
                        send_byte($urandom_range(0, 255),
                                  ($urandom_range(0, 3) == 0) ? $urandom :
                                  $urandom_range(0, 2 * rx_gap_ms + 2));
                    end
                end else begin
                    set_enable(1'b0);
                    repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255),
                                                            $urandom_range(0, 3));
                    set_enable(1'b1);
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_after_reset();
        test_register_defaults();
        test_address_filter();
        test_silence_limit();
        test_frame_full();
        test_disable_midframe();
        test_random_traffic();

        settle();
        $display("Summary: %0d beats sent, %0d bytes taken, %0d frame infos checked,",
                 beats_accepted, bytes_taken, frames_checked);
        $display("%0d register writes; covered address filter, silence limit with wrap,",
                 cfg_writes);
        $display("full frame and idle/stall mixes");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
